[src/avtc_pkg.sv]
// ----------------------------------------------------------------------------
// avtc_pkg
// shared types and constants of the audio/video timestamp corrector
// ----------------------------------------------------------------------------
package avtc_pkg;

    // stamp width of the result, the output field itself stays 32 bits wide
    localparam int STAMP_WIDTH = 32;
    localparam int STAMP_OUT_W = (STAMP_WIDTH < 32) ? STAMP_WIDTH : 32;
    localparam logic [32:0] OUT_MASK_X = (33'd1 << STAMP_OUT_W) - 33'd1;
    localparam logic [31:0] OUT_MASK = OUT_MASK_X[31:0];

    // packet kinds
    localparam logic [1:0] OP_VIDEO = 2'd0;
    localparam logic [1:0] OP_AUDIO = 2'd1;
    localparam logic [1:0] OP_OTHER = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_VIDEO_MAX   = 3'd0;
    localparam logic [2:0] CFG_VIDEO_DFLT  = 3'd1;
    localparam logic [2:0] CFG_AUDIO_MAX   = 3'd2;
    localparam logic [2:0] CFG_AUDIO_DFLT  = 3'd3;
    localparam logic [2:0] CFG_AUDIO_SYNC  = 3'd4;

    // configuration reset values
    localparam logic [15:0] RST_VIDEO_MAX  = 16'd100;
    localparam logic [15:0] RST_VIDEO_DFLT = 16'd40;
    localparam logic [15:0] RST_AUDIO_MAX  = 16'd100;
    localparam logic [15:0] RST_AUDIO_DFLT = 16'd20;

    // audio run counter saturation point
    localparam logic [1:0] RUN_SAT = 2'd2;

    // how the delta unit treats the selected base
    typedef struct packed {
        logic zero_delta;   // pass-through: base plus nothing
        logic adopt_chk;    // first video after audio: adopt audio timing if far off
    } t_avtc_ctl;

endpackage

[src/avtc_in_if.sv]
// ----------------------------------------------------------------------------
// avtc_in_if
// packet event channel: valid/ready handshake with kind, header flag and stamp
// ----------------------------------------------------------------------------
interface avtc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic        is_codec_header;
    logic [31:0] raw_stamp;

    modport source (output valid, output op, output is_codec_header,
                    output raw_stamp, input ready);
    modport sink   (input valid, input op, input is_codec_header,
                    input raw_stamp, output ready);
endinterface

[src/avtc_out_if.sv]
// ----------------------------------------------------------------------------
// avtc_out_if
// corrected timestamp channel: valid/ready handshake with one 32-bit stamp
// ----------------------------------------------------------------------------
interface avtc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] corrected_stamp;

    modport source (output valid, output corrected_stamp, input ready);
    modport sink   (input valid, input corrected_stamp, output ready);
endinterface

[src/avtc_delta_unit.sv]
// ----------------------------------------------------------------------------
// avtc_delta_unit
// measured delta, strict window check, default substitution, clamped add
// ----------------------------------------------------------------------------
module avtc_delta_unit (
    input  logic [31:0]          i_stamp,
    input  logic [31:0]          i_base_raw,
    input  logic [63:0]          i_base_fixed,
    input  logic [15:0]          i_max_delta,
    input  logic [15:0]          i_dflt_delta,
    input  avtc_pkg::t_avtc_ctl  i_ctl,
    output logic [63:0]          o_fixed
);
    import avtc_pkg::*;

    logic signed [33:0] delta;
    logic signed [33:0] max_s;
    logic signed [33:0] dflt_s;
    logic signed [33:0] eff;
    logic        [63:0] base;
    logic signed [65:0] sum;
    logic               in_win;

    assign delta  = $signed({2'b00, i_stamp}) - $signed({2'b00, i_base_raw});
    assign max_s  = $signed({18'd0, i_max_delta});
    assign dflt_s = $signed({18'd0, i_dflt_delta});
    assign in_win = (delta > -max_s) && (delta < max_s);

    always_comb begin
        priority if (i_ctl.zero_delta) begin
            eff  = '0;
            base = i_base_fixed;
        end else if (i_ctl.adopt_chk) begin
            // near enough: own stamp, delta zero; far off: audio timing plus default
            eff  = in_win ? 34'sd0 : dflt_s;
            base = in_win ? {32'd0, i_stamp} : i_base_fixed;
        end else begin
            eff  = in_win ? delta : dflt_s;
            base = i_base_fixed;
        end
    end

    assign sum = $signed({2'b00, base}) + {{32{eff[33]}}, eff};

    // clamp at zero, saturate at the top
    always_comb begin
        priority if (sum[65]) begin
            o_fixed = '0;
        end else if (sum[64]) begin
            o_fixed = '1;
        end else begin
            o_fixed = sum[63:0];
        end
    end

endmodule

[src/av_timestamp_corrector.sv]
// ----------------------------------------------------------------------------
// av_timestamp_corrector
// per-packet timestamp jitter correction for a live audio/video stream
// ----------------------------------------------------------------------------
// one packet event enters per cycle (one transaction per clock sustained)
// unless the output stalls, set by the single subtract, window compare and
// clamped 64-bit add between the input register and the per-stream state;
// one corrected stamp leaves per packet, in order, via the input and then the
// result register; video and audio keep their own last raw and corrected
// times, out-of-window deltas are replaced by the stream's default, headers
// and other packets give zero; the user must write configuration through
// i_cfg_we/i_cfg_idx/i_cfg_data while no packet is in flight (unenforced)
module av_timestamp_corrector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    avtc_in_if.sink     i_pkt,
    avtc_out_if.source  o_res
);
    import avtc_pkg::*;

    // configuration registers
    logic [15:0] r_video_max;
    logic [15:0] r_video_dflt;
    logic [15:0] r_audio_max;
    logic [15:0] r_audio_dflt;
    logic        r_audio_sync;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic        r_in_hdr;
    logic [31:0] r_in_stamp;

    // result register
    logic        r_out_valid;
    logic [31:0] r_out_stamp;

    // per-stream state
    logic [31:0] r_video_raw;
    logic        r_video_seen;
    logic [63:0] r_video_fixed;
    logic [31:0] r_audio_raw;
    logic        r_audio_seen;
    logic [63:0] r_audio_fixed;
    logic [1:0]  r_run_cnt;
    logic [1:0]  n_run_cnt;

    // datapath selection
    logic        advance;
    logic        is_video;
    logic        is_audio;
    logic        audio_via_video;
    logic [31:0] sel_base_raw;
    logic [63:0] sel_base_fixed;
    logic [15:0] sel_max;
    logic [15:0] sel_dflt;
    t_avtc_ctl   sel_ctl;
    logic [63:0] new_fixed;
    logic [31:0] n_out_stamp;

    // input stage drains into the result stage whenever that one is free
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pkt.ready = !r_in_valid || advance;

    assign o_res.valid           = r_out_valid;
    assign o_res.corrected_stamp = r_out_stamp;

    // configuration writes, unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_max  <= RST_VIDEO_MAX;
            r_video_dflt <= RST_VIDEO_DFLT;
            r_audio_max  <= RST_AUDIO_MAX;
            r_audio_dflt <= RST_AUDIO_DFLT;
            r_audio_sync <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VIDEO_MAX:  r_video_max  <= i_cfg_data;
                CFG_VIDEO_DFLT: r_video_dflt <= i_cfg_data;
                CFG_AUDIO_MAX:  r_audio_max  <= i_cfg_data;
                CFG_AUDIO_DFLT: r_audio_dflt <= i_cfg_data;
                CFG_AUDIO_SYNC: r_audio_sync <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pkt.ready) begin
            r_in_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_in_op    <= i_pkt.op;
            r_in_hdr   <= i_pkt.is_codec_header;
            r_in_stamp <= i_pkt.raw_stamp;
        end
    end

    // packet classification; headers and other kinds touch nothing
    assign is_video = !r_in_hdr && (r_in_op == OP_VIDEO);
    assign is_audio = !r_in_hdr && (r_in_op == OP_AUDIO);

    // in sync mode the first audio packet after video runs on the video clock
    assign audio_via_video = r_audio_sync && (r_run_cnt == 2'd0);

    // pick base times and window for the single shared delta unit
    always_comb begin
        sel_base_raw   = r_in_stamp;
        sel_base_fixed = {32'd0, r_in_stamp};
        sel_max        = r_video_max;
        sel_dflt       = r_video_dflt;
        sel_ctl        = '0;
        if (is_video) begin
            if (r_video_seen) begin
                sel_base_raw   = r_video_raw;
                sel_base_fixed = r_video_fixed;
            end else if (r_audio_seen) begin
                // first video: compare against audio, adopt it when far off
                sel_base_raw      = r_audio_raw;
                sel_base_fixed    = r_audio_fixed;
                sel_ctl.adopt_chk = 1'b1;
            end
        end else if (is_audio) begin
            if (audio_via_video) begin
                if (r_video_seen) begin
                    sel_base_raw   = r_video_raw;
                    sel_base_fixed = r_video_fixed;
                end else begin
                    sel_ctl.zero_delta = 1'b1;
                end
            end else begin
                sel_max  = r_audio_max;
                sel_dflt = r_audio_dflt;
                if (r_audio_seen) begin
                    sel_base_raw   = r_audio_raw;
                    sel_base_fixed = r_audio_fixed;
                end else begin
                    sel_ctl.zero_delta = 1'b1;
                end
            end
        end
    end

    avtc_delta_unit u_delta (
        .i_stamp      (r_in_stamp),
        .i_base_raw   (sel_base_raw),
        .i_base_fixed (sel_base_fixed),
        .i_max_delta  (sel_max),
        .i_dflt_delta (sel_dflt),
        .i_ctl        (sel_ctl),
        .o_fixed      (new_fixed)
    );

    // run counter: video clears it, sync-mode audio counts up to two
    always_comb begin
        n_run_cnt = r_run_cnt;
        if (is_video) begin
            n_run_cnt = '0;
        end else if (is_audio && r_audio_sync && (r_run_cnt != RUN_SAT)) begin
            n_run_cnt = r_run_cnt + 2'd1;
        end
    end

    assign n_out_stamp = (is_video || is_audio) ? (new_fixed[31:0] & OUT_MASK) : 32'd0;

    // stream state moves only when a packet leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_seen <= 1'b0;
            r_audio_seen <= 1'b0;
            r_video_raw  <= '0;
            r_audio_raw  <= '0;
            r_video_fixed <= '0;
            r_audio_fixed <= '0;
            r_run_cnt    <= '0;
        end else if (advance) begin
            r_run_cnt <= n_run_cnt;
            if (is_video) begin
                r_video_seen  <= 1'b1;
                r_video_raw   <= r_in_stamp;
                r_video_fixed <= new_fixed;
            end
            if (is_audio) begin
                r_audio_seen  <= 1'b1;
                r_audio_raw   <= r_in_stamp;
                r_audio_fixed <= new_fixed;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_stamp <= n_out_stamp;
        end
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the audio/video timestamp corrector: packets go in
// through the valid/ready channel, every accepted transaction is run through
// a local model of the per-stream correction, and each corrected stamp that
// leaves is compared in order with the stamp the model gave
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import avtc_pkg::*;

    // op value with no packet kind behind it, answered like an other packet
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int RANDOM_PHASES  = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    avtc_in_if  pkt_if ();
    avtc_out_if res_if ();

    av_timestamp_corrector uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pkt      (pkt_if),
        .o_res      (res_if)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // local copy of the correction: configuration and per-stream state
    // ------------------------------------------------------------------------
    logic [15:0] cfg_video_max;
    logic [15:0] cfg_video_dflt;
    logic [15:0] cfg_audio_max;
    logic [15:0] cfg_audio_dflt;
    logic        cfg_audio_sync;

    logic [31:0] vid_last_raw;
    logic        vid_seen;
    logic [63:0] vid_last_fixed;
    logic [31:0] aud_last_raw;
    logic        aud_seen;
    logic [63:0] aud_last_fixed;
    logic [1:0]  aud_run;

    // corrected stamps still owed by the block, oldest first
    logic [31:0] expected_stamps[$];
    logic [31:0] wanted_stamp;

    int errors       = 0;
    int quiet_cycles = 0;

    // idling controls shared by the sender, the receiver and the tests
    logic sender_idles    = 1'b1;
    logic receiver_stalls = 1'b1;
    logic hold_request    = 1'b0;

    // measured delta when strictly inside the open window, else the default
    function automatic longint window_delta(input logic [31:0] now, input logic [31:0] prev,
                                            input logic [15:0] maxd, input logic [15:0] dflt);
        longint d;
        longint m;
        d = longint'({32'd0, now}) - longint'({32'd0, prev});
        m = longint'({48'd0, maxd});
        if (d > -m && d < m)
            return d;
        return longint'({48'd0, dflt});
    endfunction

    // base plus delta, floored at zero and saturated at the top
    function automatic logic [63:0] clamped_sum(input logic [63:0] base, input longint d);
        logic [63:0] mag;
        logic [63:0] s;
        if (d < 0) begin
            mag = -d;
            return (base < mag) ? 64'd0 : base - mag;
        end
        mag = d;
        s = base + mag;
        return (s < base) ? '1 : s;
    endfunction

    // audio corrected against its own clock
    function automatic logic [63:0] step_audio_own(input logic [31:0] t);
        longint d;
        if (!aud_seen) begin
            aud_seen       = 1'b1;
            aud_last_raw   = t;
            aud_last_fixed = {32'd0, t};
            return {32'd0, t};
        end
        d = window_delta(t, aud_last_raw, cfg_audio_max, cfg_audio_dflt);
        aud_last_raw   = t;
        aud_last_fixed = clamped_sum(aud_last_fixed, d);
        return aud_last_fixed;
    endfunction

    // sync mode: first audio after video follows the video clock
    function automatic logic [63:0] step_audio_synced(input logic [31:0] t);
        longint d;
        if (aud_run < RUN_SAT)
            aud_run = aud_run + 2'd1;
        if (aud_run > 2'd1)
            return step_audio_own(t);
        aud_seen     = 1'b1;
        aud_last_raw = t;
        if (!vid_seen) begin
            aud_last_fixed = {32'd0, t};
            return {32'd0, t};
        end
        d = window_delta(t, vid_last_raw, cfg_video_max, cfg_video_dflt);
        aud_last_fixed = clamped_sum(vid_last_fixed, d);
        return aud_last_fixed;
    endfunction

    function automatic logic [63:0] step_video(input logic [31:0] t);
        longint d;
        longint gap;
        longint m;
        aud_run = 2'd0;
        if (!vid_seen) begin
            vid_seen       = 1'b1;
            vid_last_raw   = t;
            vid_last_fixed = {32'd0, t};
            // first video adopts the audio timing when it is far off
            if (aud_seen) begin
                gap = longint'({32'd0, aud_last_raw}) - longint'({32'd0, t});
                m   = longint'({48'd0, cfg_video_max});
                if (gap <= -m || gap >= m) begin
                    vid_last_raw   = aud_last_raw;
                    vid_last_fixed = aud_last_fixed;
                end
            end
        end
        d = window_delta(t, vid_last_raw, cfg_video_max, cfg_video_dflt);
        vid_last_raw   = t;
        vid_last_fixed = clamped_sum(vid_last_fixed, d);
        return vid_last_fixed;
    endfunction

    // expected corrected stamp of one packet, advancing the local state
    function automatic logic [31:0] correct_stamp(input logic [1:0] op, input logic hdr,
                                                  input logic [31:0] t);
        logic [63:0] r;
        r = 64'd0;
        if (!hdr) begin
            if (op == OP_VIDEO)
                r = step_video(t);
            else if (op == OP_AUDIO)
                r = cfg_audio_sync ? step_audio_synced(t) : step_audio_own(t);
        end
        return r[31:0] & OUT_MASK;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_window();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hffff;
            3, 4, 5: return 16'($urandom_range(2, 200));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_default();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hffff;
            2, 3: return 16'($urandom_range(1, 1000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // stamp that mostly tracks the clock the packet will be measured against,
    // often right at the window edge, sometimes far away or at the extremes
    function automatic logic [31:0] pick_stamp(input logic [1:0] op);
        logic [31:0] base;
        logic [15:0] m;
        int          span;
        int          off;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom;
        if (r < 12)
            return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'd0;
        if (op == OP_AUDIO && !(cfg_audio_sync && aud_run == 2'd0 && vid_seen)) begin
            base = aud_last_raw;
            m    = cfg_audio_max;
        end else begin
            base = vid_last_raw;
            m    = cfg_video_max;
        end
        span = int'(m) + 2;
        if (r < 30) begin
            off = int'(m) - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) != 0)
                off = -off;
        end else begin
            off = int'($urandom_range(0, 2 * span)) - span;
        end
        return base + 32'(off);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offers one packet and waits for its transaction; valid stays high after
    // it so that back-to-back packets never drop valid between them
    task automatic send_packet(input logic [1:0] op, input logic hdr, input logic [31:0] t);
        int idle;
        idle = sender_idles ? pick_idle() : 0;
        if (idle > 0) begin
            @(negedge i_clk);
            pkt_if.valid = 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pkt_if.valid           = 1'b1;
        pkt_if.op              = op;
        pkt_if.is_codec_header = hdr;
        pkt_if.raw_stamp       = t;
        @(posedge i_clk);
        while (!pkt_if.ready)
            @(posedge i_clk);
        expected_stamps.push_back(correct_stamp(op, hdr, t));
    endtask

    // sender goes quiet until every owed stamp has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        pkt_if.valid = 1'b0;
        while (expected_stamps.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_VIDEO_MAX:  cfg_video_max  = data;
            CFG_VIDEO_DFLT: cfg_video_dflt = data;
            CFG_AUDIO_MAX:  cfg_audio_max  = data;
            CFG_AUDIO_DFLT: cfg_audio_dflt = data;
            CFG_AUDIO_SYNC: cfg_audio_sync = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // full register set; the sync bit goes out with junk in the upper bits
    task automatic configure(input logic [15:0] vmax, input logic [15:0] vdflt,
                             input logic [15:0] amax, input logic [15:0] adflt,
                             input logic sync);
        write_reg(CFG_VIDEO_MAX, vmax);
        write_reg(CFG_VIDEO_DFLT, vdflt);
        write_reg(CFG_AUDIO_MAX, amax);
        write_reg(CFG_AUDIO_DFLT, adflt);
        write_reg(CFG_AUDIO_SYNC, {15'($urandom), sync});
    endtask

    task automatic send_random_packet();
        logic [1:0] op;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 42)
            op = OP_VIDEO;
        else if (r < 84)
            op = OP_AUDIO;
        else if (r < 92)
            op = OP_OTHER;
        else
            op = OP_SPARE;
        send_packet(op, ($urandom_range(0, 99) < 8), pick_stamp(op));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // straight after reset with reset windows and sync mode on: audio before
    // any video, the ignored kinds, negative sums, first video far from audio
    task automatic test_sync_startup();
        write_reg(CFG_AUDIO_SYNC, 16'd1);
        send_packet(OP_AUDIO, 1'b0, 32'd50);        // no video yet: passes through
        send_packet(OP_AUDIO, 1'b1, 32'd9999);      // codec header
        send_packet(OP_OTHER, 1'b0, 32'd123);
        send_packet(OP_SPARE, 1'b0, 32'd77);
        send_packet(OP_AUDIO, 1'b0, 32'd150);       // delta on the edge: default
        send_packet(OP_AUDIO, 1'b0, 32'd60);        // sum below zero clamps
        send_packet(OP_VIDEO, 1'b0, 32'd5000);      // first video adopts audio timing
        send_packet(OP_AUDIO, 1'b0, 32'd5010);      // measured on the video clock
        send_packet(OP_AUDIO, 1'b0, 32'd5030);      // second in a row: own clock
        send_packet(OP_VIDEO, 1'b1, 32'd0);
        send_packet(OP_VIDEO, 1'b0, 32'd4950);      // video sum clamps
        send_packet(OP_AUDIO, 1'b0, 32'd0);
        send_packet(OP_VIDEO, 1'b0, 32'hffff_ffff);
        send_packet(OP_AUDIO, 1'b0, 32'hffff_fff0);
        send_packet(OP_AUDIO, 1'b0, 32'hffff_ffff);
        send_packet(OP_OTHER, 1'b1, 32'hffff_ffff);
        send_packet(OP_SPARE, 1'b1, 32'd0);
        wait_for_results();
    endtask

    // empty windows: every delta is replaced, defaults at both extremes
    task automatic test_zero_window();
        configure(16'd0, 16'hffff, 16'd0, 16'd0, 1'b0);
        send_packet(OP_VIDEO, 1'b0, vid_last_raw);
        send_packet(OP_AUDIO, 1'b0, aud_last_raw);
        send_packet(OP_VIDEO, 1'b0, vid_last_raw + 32'd1);
        send_packet(OP_AUDIO, 1'b0, aud_last_raw - 32'd1);
        send_packet(OP_AUDIO, 1'b0, 32'h8000_0000);
        wait_for_results();
    endtask

    // widest windows: deltas just inside and exactly on the edge
    task automatic test_wide_window();
        configure(16'hffff, 16'd0, 16'hffff, 16'hffff, 1'b1);
        send_packet(OP_VIDEO, 1'b0, vid_last_raw + 32'd65534);
        send_packet(OP_VIDEO, 1'b0, vid_last_raw - 32'd65535);
        send_packet(OP_AUDIO, 1'b0, vid_last_raw + 32'd65535);
        send_packet(OP_AUDIO, 1'b0, aud_last_raw - 32'd65534);
        wait_for_results();
    endtask

    // phases of random traffic, each under its own register setting
    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            configure(pick_window(), pick_default(), pick_window(), pick_default(),
                      ($urandom_range(0, 1) != 0));
            // one phase runs flat out on both sides
            sender_idles    = (p != 1) && ($urandom_range(0, 3) != 0);
            receiver_stalls = (p != 1) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_packet();
            wait_for_results();
        end
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // receiver holds off while packets keep coming, so the block backs up
    // and stalls its input until the hold ends
    task automatic test_output_hold();
        configure(16'd100, 16'd40, 16'd100, 16'd20, 1'b0);
        sender_idles = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
            send_random_packet();
        sender_idles = 1'b1;
        wait_for_results();
    endtask

    // sender stops mid-stream until everything owed has come back
    task automatic test_input_pause();
        configure(pick_window(), pick_default(), pick_window(), pick_default(), 1'b1);
        for (int i = 0; i < 12; i++)
            send_random_packet();
        wait_for_results();
        for (int i = 0; i < 12; i++)
            send_random_packet();
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // receiver: ready with random stalls, plus the long hold when asked
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
                if (receiver_stalls)
                    stall_left = pick_idle();
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check: each output transaction against the oldest owed stamp
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_stamps.size() == 0) begin
                $error("unexpected result: corrected_stamp %0h", res_if.corrected_stamp);
                errors++;
            end else begin
                wanted_stamp = expected_stamps.pop_front();
                if (res_if.corrected_stamp !== wanted_stamp) begin
                    $error("corrected_stamp: expected %0h, actual %0h",
                           wanted_stamp, res_if.corrected_stamp);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_VIDEO_MAX;
        i_cfg_data             = 16'd0;
        pkt_if.valid           = 1'b0;
        pkt_if.op              = OP_VIDEO;
        pkt_if.is_codec_header = 1'b0;
        pkt_if.raw_stamp       = 32'd0;

        // model starts from the reset state of the block
        cfg_video_max  = RST_VIDEO_MAX;
        cfg_video_dflt = RST_VIDEO_DFLT;
        cfg_audio_max  = RST_AUDIO_MAX;
        cfg_audio_dflt = RST_AUDIO_DFLT;
        cfg_audio_sync = 1'b0;
        vid_last_raw   = 32'd0;
        vid_seen       = 1'b0;
        vid_last_fixed = 64'd0;
        aud_last_raw   = 32'd0;
        aud_seen       = 1'b0;
        aud_last_fixed = 64'd0;
        aud_run        = 2'd0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_sync_startup();
        test_zero_window();
        test_wide_window();
        test_output_hold();
        test_random_phases();
        test_input_pause();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_stamps.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
